// ===== src/svf_pkg.sv =====
// svf_pkg: widths, reset values, register indexes, sequencer states and shift
// helpers for the resonant state variable filter.
// No dependencies.
package svf_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int COEF_W            = 9;
  localparam int ACC_W             = 32;
  localparam int OUT_W             = 28;
  localparam int CFG_IDX_W         = 1;
  localparam int MUL_W             = ACC_W + COEF_W;
  localparam int DEF_NUM_CHANNELS  = 2;

  localparam logic [COEF_W-1:0] CUTOFF_RESET  = COEF_W'(0);
  localparam logic [COEF_W-1:0] DAMPING_RESET = COEF_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF  = 1'b0,
    REG_DAMPING = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_F,
    ST_MUL_Q,
    ST_HIGH,
    ST_MUL_H,
    ST_DONE
  } svf_state_t;

  function automatic logic [ACC_W-1:0] sra8(input logic [ACC_W-1:0] v);
    return ACC_W'($signed(v) >>> 8);
  endfunction

  function automatic logic [SAMPLE_W+3:0] scale16(input logic [SAMPLE_W-1:0] s);
    return {s, 4'b0000};
  endfunction

endpackage

// ===== src/svf_in_if.sv =====
// svf_in_if: sample input channel, valid/ready with sample and channel.
// Depends on svf_pkg.
interface svf_in_if;
  import svf_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        channel;

  modport source (output valid, sample, channel, input ready);
  modport sink   (input valid, sample, channel, output ready);
endinterface

// ===== src/svf_out_if.sv =====
// svf_out_if: result channel, valid/ready with lowpass, bandpass, highpass
// and channel. Depends on svf_pkg.
interface svf_out_if;
  import svf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  low_out;
  logic signed [OUT_W-1:0]  band_out;
  logic signed [OUT_W-1:0]  high_out;
  logic                     out_channel;

  modport source (output valid, low_out, band_out, high_out, out_channel, input ready);
  modport sink   (input valid, low_out, band_out, high_out, out_channel, output ready);
endinterface

// ===== src/svf_cfg_if.sv =====
// svf_cfg_if: register write channel, valid/ready with index and data.
// Depends on svf_pkg.
interface svf_cfg_if;
  import svf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [COEF_W-1:0]     data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== src/resonant_state_variable_filter.sv =====
// resonant_state_variable_filter: two-integrator resonant filter, one shared
// 32x9 multiplier under a six-state sequencer. Depends on svf_pkg and the
// svf_in_if, svf_out_if and svf_cfg_if interfaces.
//
//   channel   | dir | word
//   in_chan   | in  | sample[15:0] signed, channel
//   out_chan  | out | low_out, band_out, high_out [27:0] signed, out_channel
//   cfg_chan  | in  | reg_index (0 cutoff, 1 damping), data[8:0]
//
// A word passes through MUL_F, MUL_Q, HIGH, MUL_H and DONE to a valid result,
// and the next word is taken only back in IDLE: three products go through the single
// multiplier, each one registered before use.
// Reset clears the integrators of every channel and sets the coefficients.
// A stalled result holds the sequencer in its last state; the input stays
// not ready until the result is loaded. Register writes are always taken.
module resonant_state_variable_filter #(
  parameter int NUM_CHANNELS = svf_pkg::DEF_NUM_CHANNELS
) (
  input  logic      clk,
  input  logic      rst_n,
  svf_in_if.sink    in_chan,
  svf_out_if.source out_chan,
  svf_cfg_if.sink   cfg_chan
);
  import svf_pkg::*;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  svf_state_t state_r, state_nxt;

  logic [COEF_W-1:0]   cutoff_r, damping_r;
  logic [ACC_W-1:0]    band_mem_r [NUM_CHANNELS];
  logic [ACC_W-1:0]    low_mem_r  [NUM_CHANNELS];

  logic [ACC_W-1:0]    x_r, band_r, low_r, high_r, prod_r;
  logic [CH_IDX_W-1:0] ch_idx_r;
  logic                chan_r;

  logic [OUT_W-1:0]    low_out_r, band_out_r, high_out_r;
  logic                out_chan_r, out_valid_r, out_valid_nxt;

  logic [COEF_W-1:0]   mul_a;
  logic [ACC_W-1:0]    mul_b;
  logic [MUL_W-1:0]    mul_full;
  logic [ACC_W-1:0]    band_new;
  logic [CH_IDX_W-1:0] ch_idx_in;
  logic                in_acc, out_load;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign ch_idx_in      = (NUM_CHANNELS == 1) ? '0 : CH_IDX_W'(in_chan.channel);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.low_out     = low_out_r;
  assign out_chan.band_out    = band_out_r;
  assign out_chan.high_out    = high_out_r;
  assign out_chan.out_channel = out_chan_r;

  assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign band_new = sra8(prod_r) + band_r;

  always_comb begin
    state_nxt     = state_r;
    mul_a         = cutoff_r;
    mul_b         = band_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MUL_F;
      end
      ST_MUL_F: state_nxt = ST_MUL_Q;
      ST_MUL_Q: begin
        mul_a     = damping_r;
        state_nxt = ST_HIGH;
      end
      ST_HIGH: state_nxt = ST_MUL_H;
      ST_MUL_H: begin
        mul_b     = high_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cutoff_r    <= CUTOFF_RESET;
      damping_r   <= DAMPING_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        band_mem_r[i] <= '0;
        low_mem_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.reg_index)
          REG_CUTOFF:  cutoff_r  <= cfg_chan.data;
          REG_DAMPING: damping_r <= cfg_chan.data;
          default: ;
        endcase
      end
      if (out_load) begin
        band_mem_r[ch_idx_r] <= band_new;
        low_mem_r[ch_idx_r]  <= low_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r      <= ACC_W'($signed(scale16(in_chan.sample)));
      band_r   <= band_mem_r[ch_idx_in];
      low_r    <= low_mem_r[ch_idx_in];
      ch_idx_r <= ch_idx_in;
      chan_r   <= in_chan.channel;
    end
    if (state_r == ST_MUL_F || state_r == ST_MUL_Q || state_r == ST_MUL_H) begin
      prod_r <= mul_full[ACC_W-1:0];
    end
    if (state_r == ST_MUL_Q) begin
      low_r <= low_r + sra8(prod_r);
    end
    if (state_r == ST_HIGH) begin
      high_r <= x_r - low_r - sra8(prod_r);
    end
    if (out_load) begin
      low_out_r  <= low_r[ACC_W-1:ACC_W-OUT_W];
      band_out_r <= band_new[ACC_W-1:ACC_W-OUT_W];
      high_out_r <= high_r[ACC_W-1:ACC_W-OUT_W];
      out_chan_r <= chan_r;
    end
  end

endmodule

// ===== src/svf_checker.sv =====
// svf_checker: port-level checks of the filter's handshakes, bound to the
// top level. Depends on svf_pkg.
module svf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [svf_pkg::OUT_W-1:0]   out_low,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);
  import svf_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low))
    else $error("stalled result dropped or changed");

endmodule

bind resonant_state_variable_filter svf_checker u_svf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_low   (out_chan.low_out),
  .cfg_valid (cfg_chan.valid),
  .cfg_ready (cfg_chan.ready)
);
